// ----- rtl/rtld_pkg.sv -----
// ----------------------------------------------------------------------------
// rtld_pkg: shared types and codes of the record table
// Operation and status codes, the record and probe types passed along the
// cell chain, and the control group broadcast to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package rtld_pkg;

    localparam int DEFAULT_CAPACITY = 32;

    localparam int KEY_W   = 16;
    localparam int NAME_W  = 16;
    localparam int SCORE_W = 7;

    localparam logic [SCORE_W-1:0] MAX_SCORE = 7'd100;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_ERASE  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [NAME_W-1:0]  name;
        logic [SCORE_W-1:0] score;
    } t_rec;

    // Search item that walks the chain, one cell per cycle.
    typedef struct packed {
        logic             act;
        logic             erase;
        logic [KEY_W-1:0] key;
        logic             hit;
        t_rec             rec;
    } t_probe;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/rtld_cell.sv -----
// ----------------------------------------------------------------------------
// rtld_cell: one slot of the record table
// Holds one record, loads it on insert, takes its upper neighbor's record
// when the gap closes, and updates the passing probe.
// ----------------------------------------------------------------------------
`default_nettype none

module rtld_cell #(
    parameter int CAPACITY = rtld_pkg::DEFAULT_CAPACITY,
    parameter int IDX      = 0,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rtld_pkg::t_cell_ctl   i_ctl,
    input  rtld_pkg::t_rec        i_wr_rec,
    input  rtld_pkg::t_rec        i_nxt_rec,
    input  wire  [CNT_W-1:0]      i_count,
    input  wire  [IDX_W-1:0]      i_sel,
    input  rtld_pkg::t_probe      i_probe,
    input  wire  [IDX_W-1:0]      i_idx,
    output rtld_pkg::t_probe      o_probe,
    output logic [IDX_W-1:0]      o_idx,
    output rtld_pkg::t_rec        o_rec
);

    rtld_pkg::t_rec   r_rec;
    rtld_pkg::t_probe r_probe, n_probe;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             w_occ;

    assign w_occ = i_count > CNT_W'(IDX);

    always_comb begin
        n_probe = i_probe;
        n_idx   = i_idx;
        if (i_probe.act && w_occ) begin
            if (!i_probe.erase) begin
                // first match wins: later cells see hit and pass through
                if (!i_probe.hit && r_rec.key == i_probe.key) begin
                    n_probe.hit = 1'b1;
                    n_probe.rec = r_rec;
                    n_idx       = IDX_W'(IDX);
                end
            end else begin
                // strict less-than keeps the earliest of equal scores
                if (!i_probe.hit || r_rec.score < i_probe.rec.score) begin
                    n_probe.hit = 1'b1;
                    n_probe.rec = r_rec;
                    n_idx       = IDX_W'(IDX);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_count == CNT_W'(IDX)) begin
            r_rec <= i_wr_rec;
        end else if (i_ctl.shift && IDX_W'(IDX) >= i_sel) begin
            r_rec <= i_nxt_rec;
        end
    end

    assign o_probe = r_probe;
    assign o_idx   = r_idx;
    assign o_rec   = r_rec;

endmodule

`default_nettype wire

// ----- rtl/record_table_lookup_delete_min.sv -----
// ----------------------------------------------------------------------------
// record_table_lookup_delete_min: ordered record table with key lookup and
// erase of the lowest score
// A chain of CAPACITY cells holds the records; searches walk the chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_mode, i_key_id, i_name_ref and
//   i_score_in. Output channel: o_valid / i_stall with o_status, o_found_id,
//   o_found_name_ref and o_found_score. Every item gives one result.
//   One item is worked on at a time; o_stall stays high until its result
//   has moved into the output register.
//   Insert, mode 3, insert into a full table and erase on an empty table:
//   result registered on acceptance, then moved to the output register.
//   Lookup and erase: a probe passes the chain one cell per cycle, and the
//   result is registered when it leaves the last cell, then moved to the
//   output register; the erase closes the gap in the cycle the probe
//   leaves the last cell.
//   When the receiver stalls, the result holds in the output register and
//   one more item can be accepted and finished behind it.
//   Reset clears the record count, the state machine and the output valid;
//   record contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module record_table_lookup_delete_min #(
    parameter int CAPACITY = rtld_pkg::DEFAULT_CAPACITY
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_mode,
    input  wire  [15:0] i_key_id,
    input  wire  [15:0] i_name_ref,
    input  wire  [6:0]  i_score_in,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_found_id,
    output logic [15:0] o_found_name_ref,
    output logic [6:0]  o_found_score
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [1:0]           r_res_status, n_res_status;
    rtld_pkg::t_rec       r_res_rec, n_res_rec;
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_status, n_out_status;
    rtld_pkg::t_rec       r_out_rec, n_out_rec;

    rtld_pkg::t_cell_ctl  w_ctl;
    rtld_pkg::t_rec       w_wr_rec;
    logic [IDX_W-1:0]     w_sel;
    logic                 w_acc;
    logic                 w_full;
    logic                 w_out_free;

    rtld_pkg::t_probe     w_probe [0:CAPACITY];
    logic [IDX_W-1:0]     w_idx   [0:CAPACITY];
    rtld_pkg::t_rec       w_rec   [0:CAPACITY];

    assign o_stall    = r_state != S_IDLE;
    assign w_acc      = i_valid && !o_stall;
    assign w_full     = r_count == CNT_W'(CAPACITY);
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_wr_rec.key   = i_key_id;
    assign w_wr_rec.name  = i_name_ref;
    assign w_wr_rec.score = (i_score_in > rtld_pkg::MAX_SCORE) ? rtld_pkg::MAX_SCORE
                                                               : i_score_in;

    // launch a probe only for searches that walk the table
    assign w_probe[0] = '{
        act:   w_acc && (i_mode == rtld_pkg::MODE_LOOKUP ||
               (i_mode == rtld_pkg::MODE_ERASE && r_count != '0)),
        erase: i_mode == rtld_pkg::MODE_ERASE,
        key:   i_key_id,
        hit:   1'b0,
        rec:   '0
    };
    assign w_idx[0]        = '0;
    assign w_rec[CAPACITY] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            rtld_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_wr_rec  (w_wr_rec),
                .i_nxt_rec (w_rec[g+1]),
                .i_count   (r_count),
                .i_sel     (w_sel),
                .i_probe   (w_probe[g]),
                .i_idx     (w_idx[g]),
                .o_probe   (w_probe[g+1]),
                .o_idx     (w_idx[g+1]),
                .o_rec     (w_rec[g])
            );
        end
    endgenerate

    assign w_sel = w_idx[CAPACITY];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_rec    = r_res_rec;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_rec    = r_out_rec;
        w_ctl        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_res_status = rtld_pkg::ST_OK;
                    n_res_rec    = '0;
                    n_state      = S_DONE;
                    priority if (i_mode == rtld_pkg::MODE_INSERT) begin
                        if (w_full) begin
                            n_res_status = rtld_pkg::ST_FULL;
                        end else begin
                            w_ctl.wr = 1'b1;
                            n_count  = CNT_W'(r_count + 1'b1);
                        end
                    end else if (i_mode == rtld_pkg::MODE_LOOKUP) begin
                        n_state = S_SCAN;
                    end else if (i_mode == rtld_pkg::MODE_ERASE) begin
                        if (r_count == '0) begin
                            n_res_status = rtld_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_res_status = rtld_pkg::ST_OK;
                    end
                end
            end
            S_SCAN: begin
                // the probe leaves the last cell
                if (w_probe[CAPACITY].act) begin
                    n_state = S_DONE;
                    if (w_probe[CAPACITY].hit) begin
                        n_res_status = rtld_pkg::ST_OK;
                        n_res_rec    = w_probe[CAPACITY].rec;
                    end else begin
                        n_res_status = rtld_pkg::ST_NOT_FOUND;
                        n_res_rec    = '0;
                    end
                    if (w_probe[CAPACITY].erase) begin
                        w_ctl.shift = 1'b1;
                        n_count     = CNT_W'(r_count - 1'b1);
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_rec    = r_res_rec;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_rec    <= n_res_rec;
        r_out_status <= n_out_status;
        r_out_rec    <= n_out_rec;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_id       = r_out_rec.key;
    assign o_found_name_ref = r_out_rec.name;
    assign o_found_score    = r_out_rec.score;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("record count beyond capacity");

    a_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[CAPACITY].act |-> r_state == S_SCAN)
        else $error("probe left the chain outside a search");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_mode == rtld_pkg::MODE_INSERT && !w_full)
        |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("insert did not grow the table");

    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_probe[CAPACITY].act) |=> r_state == S_SCAN)
        else $error("search ended before the probe left the chain");

endmodule

`default_nettype wire

// ----- test/record_table_lookup_delete_min_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_table_lookup_delete_min_test: self-checking bench for the record table
// A shadow copy of the table predicts the reply of every accepted item.
// Directed items cover the edge cases. Random phases then alternately fill
// and drain the table so that full and empty are hit again and again. Both
// handshakes idle at random, with one quiet stretch.
// ----------------------------------------------------------------------------
module record_table_lookup_delete_min_test;

    localparam int          CAPACITY     = rtld_pkg::DEFAULT_CAPACITY;
    localparam int          CLK_PERIOD   = 8;
    localparam int          RANDOM_ITEMS = 1530;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          REPORT_MAX   = 10;
    localparam logic [1:0]  MODE_NOP     = 2'd3;

    typedef struct packed {
        logic [1:0]                   status;
        logic [rtld_pkg::KEY_W-1:0]   id;
        logic [rtld_pkg::NAME_W-1:0]  name;
        logic [rtld_pkg::SCORE_W-1:0] score;
    } t_reply;

    // Shadow of the table contents plus the replies still owed by the block.
    class record_table_shadow;
        rtld_pkg::t_rec records[$];
        t_reply         awaited_replies[$];
        int unsigned    fail_count;

        function new();
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return awaited_replies.size();
        endfunction

        function void report(string what, t_reply want, t_reply got);
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display({"mismatch (%s): expected st=%0d id=%h name=%h score=%0d, ",
                          "got st=%0d id=%h name=%h score=%0d"},
                         what, want.status, want.id, want.name, want.score,
                         got.status, got.id, got.name, got.score);
        endfunction

        function void apply_request(logic [1:0] mode, logic [rtld_pkg::KEY_W-1:0] key,
                                    logic [rtld_pkg::NAME_W-1:0] name,
                                    logic [rtld_pkg::SCORE_W-1:0] score);
            t_reply         reply;
            rtld_pkg::t_rec rec;
            int             idx;
            int             hit;
            reply = '0;
            reply.status = rtld_pkg::ST_OK;
            case (mode)
                rtld_pkg::MODE_INSERT: begin
                    if (records.size() >= CAPACITY) begin
                        reply.status = rtld_pkg::ST_FULL;
                    end else begin
                        rec.key   = key;
                        rec.name  = name;
                        rec.score = (score > rtld_pkg::MAX_SCORE) ? rtld_pkg::MAX_SCORE
                                                                  : score;
                        records.insert(records.size(), rec);
                    end
                end
                rtld_pkg::MODE_LOOKUP: begin
                    hit = -1;
                    for (idx = 0; idx < records.size() && hit < 0; idx++)
                        if (records[idx].key == key)
                            hit = idx;
                    if (hit < 0) begin
                        reply.status = rtld_pkg::ST_NOT_FOUND;
                    end else begin
                        reply.id    = records[hit].key;
                        reply.name  = records[hit].name;
                        reply.score = records[hit].score;
                    end
                end
                rtld_pkg::MODE_ERASE: begin
                    if (records.size() == 0) begin
                        reply.status = rtld_pkg::ST_EMPTY;
                    end else begin
                        // earliest record wins a tie on the lowest score
                        hit = 0;
                        for (idx = 1; idx < records.size(); idx++)
                            if (records[idx].score < records[hit].score)
                                hit = idx;
                        reply.id    = records[hit].key;
                        reply.name  = records[hit].name;
                        reply.score = records[hit].score;
                        records.delete(hit);
                    end
                end
                default: begin
                end
            endcase
            awaited_replies.insert(awaited_replies.size(), reply);
        endfunction

        function void compare_reply(logic [1:0] status, logic [rtld_pkg::KEY_W-1:0] id,
                                    logic [rtld_pkg::NAME_W-1:0] name,
                                    logic [rtld_pkg::SCORE_W-1:0] score);
            t_reply got;
            t_reply want;
            got.status = status;
            got.id     = id;
            got.name   = name;
            got.score  = score;
            if (awaited_replies.size() == 0) begin
                report("no item pending", '0, got);
            end else begin
                want = awaited_replies.pop_front();
                if (got.status !== want.status || got.id !== want.id ||
                    got.name !== want.name || got.score !== want.score)
                    report("field", want, got);
            end
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               o_stall;
    logic [1:0]         i_mode     = MODE_NOP;
    logic [15:0]        i_key_id   = '0;
    logic [15:0]        i_name_ref = '0;
    logic [6:0]         i_score_in = '0;
    logic               o_valid;
    logic               i_stall    = 1'b0;
    logic [1:0]         o_status;
    logic [15:0]        o_found_id;
    logic [15:0]        o_found_name_ref;
    logic [6:0]         o_found_score;

    bit                 quiet = 1'b0;
    int unsigned        cycle_count;
    record_table_shadow table_shadow;

    record_table_lookup_delete_min #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_key_id        (i_key_id),
        .i_name_ref      (i_name_ref),
        .i_score_in      (i_score_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_found_id      (o_found_id),
        .o_found_name_ref(o_found_name_ref),
        .o_found_score   (o_found_score)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic send_item(input logic [1:0] mode, input logic [15:0] key,
                             input logic [15:0] name, input logic [6:0] score);
        while (!quiet && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_key_id   <= key;
        i_name_ref <= name;
        i_score_in <= score;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        table_shadow.apply_request(mode, key, name, score);
    endtask

    // Hold off the sender until every reply owed has come back.
    task automatic drain_replies();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (table_shadow.pending() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            table_shadow.compare_reply(o_status, o_found_id, o_found_name_ref,
                                       o_found_score);
        i_stall <= !quiet && ($urandom_range(99) < 34);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned step;
        int unsigned phase_len;
        int unsigned roll;
        int unsigned pick;
        bit          filling;
        logic [1:0]  mode;
        logic [15:0] key;
        logic [6:0]  score;

        table_shadow = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, unused mode, saturation, duplicate keys, score ties
        send_item(rtld_pkg::MODE_ERASE,  16'h0000, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_LOOKUP, 16'h0000, 16'h0000, 7'd0);
        send_item(MODE_NOP,              16'h0000, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_INSERT, 16'hFFFF, 16'h0000, 7'd127);
        send_item(rtld_pkg::MODE_INSERT, 16'h0000, 16'hFFFF, 7'd0);
        send_item(rtld_pkg::MODE_INSERT, 16'h1234, 16'h5555, 7'd101);
        send_item(rtld_pkg::MODE_INSERT, 16'h1234, 16'hAAAA, 7'd50);
        send_item(rtld_pkg::MODE_INSERT, 16'hABCD, 16'h0001, 7'd100);
        send_item(rtld_pkg::MODE_LOOKUP, 16'h1234, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_LOOKUP, 16'hFFFF, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_LOOKUP, 16'h0000, 16'hFFFF, 7'd127);
        send_item(rtld_pkg::MODE_LOOKUP, 16'h4321, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_ERASE,  16'h0000, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_ERASE,  16'hFFFF, 16'hFFFF, 7'd127);
        send_item(rtld_pkg::MODE_ERASE,  16'h0000, 16'h0000, 7'd0);
        send_item(MODE_NOP,              16'hFFFF, 16'hFFFF, 7'd127);
        send_item(rtld_pkg::MODE_ERASE,  16'h0000, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_ERASE,  16'h0000, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_ERASE,  16'h0000, 16'h0000, 7'd0);
        send_item(rtld_pkg::MODE_INSERT, 16'h8000, 16'h7FFF, 7'd64);
        send_item(rtld_pkg::MODE_LOOKUP, 16'h8000, 16'h0000, 7'd0);
        drain_replies();

        // alternate phases that push toward full and toward empty
        sent    = 0;
        filling = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(90, 40);
            for (step = 0; step < phase_len && sent < RANDOM_ITEMS; step++) begin
                quiet = (sent >= 700 && sent < 900);
                roll  = $urandom_range(99);
                if (roll < 60)
                    mode = filling ? rtld_pkg::MODE_INSERT : rtld_pkg::MODE_ERASE;
                else if (roll < 85)
                    mode = rtld_pkg::MODE_LOOKUP;
                else if (roll < 95)
                    mode = filling ? rtld_pkg::MODE_ERASE : rtld_pkg::MODE_INSERT;
                else
                    mode = MODE_NOP;

                // small key pool makes duplicates; lookups mostly aim at held keys
                if (mode == rtld_pkg::MODE_LOOKUP && table_shadow.records.size() != 0 &&
                    $urandom_range(99) < 75) begin
                    pick = $urandom_range(table_shadow.records.size() - 1);
                    key  = table_shadow.records[pick].key;
                end else if ($urandom_range(1) == 0) begin
                    key = 16'($urandom_range(15));
                end else begin
                    key = 16'($urandom);
                end

                roll = $urandom_range(99);
                if (roll < 60)
                    score = 7'($urandom_range(100));
                else if (roll < 80)
                    score = 7'($urandom_range(43, 40));
                else if (roll < 90)
                    score = ($urandom_range(1) == 0) ? 7'd0 : rtld_pkg::MAX_SCORE;
                else
                    score = 7'($urandom_range(127, 101));

                send_item(mode, key, 16'($urandom), score);
                sent++;
            end
            filling = !filling;
            if ($urandom_range(2) == 0)
                drain_replies();
        end
        quiet = 1'b0;

        drain_replies();
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (table_shadow.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
